// ===== rtl/core/iso_epoch_pkg.sv =====
// Shared types, constants and table functions for the timestamp-to-epoch converter.
package iso_epoch_pkg;

  localparam int unsigned TEXT_LEN = 25;
  localparam logic [4:0] POS_LAST = 5'(TEXT_LEN);
  localparam logic [7:0] DIGIT_SLOT = 8'h00;
  localparam logic [13:0] YEAR_MIN = 14'd1970;
  localparam logic [13:0] YEAR_MAX = 14'd2099;
  localparam logic [31:0] SEC_PER_DAY = 32'd86400;
  localparam logic [31:0] OFFSET_SECONDS = 32'(7 * 60 * 60);

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_data_t;

  typedef struct packed {
    logic [31:0] epoch_seconds;
    logic        valid_res;
  } out_data_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_MUL,
    ST_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic take;      // fold the presented character
    logic calc;      // range check, day count, time of day
    logic mul;       // days to seconds
    logic fin_load;  // load result register, clear text state
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_status_t;

  // Required character at a text position; DIGIT_SLOT marks a digit.
  function automatic logic [7:0] expected_char(input logic [4:0] pos);
    logic [7:0] c;
    case (pos)
      5'd4, 5'd7:          c = 8'h2D;  // '-'
      5'd10:               c = 8'h54;  // 'T'
      5'd13, 5'd16, 5'd22: c = 8'h3A;  // ':'
      5'd19:               c = 8'h2B;  // '+'
      5'd20, 5'd23, 5'd24: c = 8'h30;  // '0'
      5'd21:               c = 8'h37;  // '7'
      default:             c = DIGIT_SLOT;
    endcase
    return c;
  endfunction

  // Days of the year before the first of the month (non-leap).
  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd2:                       d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    d = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:         d = 5'd31;
      default:                    d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/iso_epoch_ctrl.sv =====
// Sequencer: character intake, then three conversion steps and result hand-off.
module iso_epoch_ctrl
  import iso_epoch_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_is_last,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_is_last) state_nxt = ST_CALC;
      end
      ST_CALC: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_FIN;
      ST_FIN: begin
        if (!status.out_full) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_CALC: cmd.calc = 1'b1;
      ST_MUL:  cmd.mul  = 1'b1;
      ST_FIN:  cmd.fin_load = !status.out_full;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/iso_epoch_dp.sv =====
// Datapath: per-character checks and digit folding, date math, result register.
module iso_epoch_dp
  import iso_epoch_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_data_t   in_data,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output logic       out_valid,
  input  logic       out_ready,
  output out_data_t  out_data
);

  logic [4:0]  pos_r;
  logic        failed_r;
  logic [13:0] year_r;
  logic [6:0]  month_r, day_r, hour_r, min_r, sec_r;

  logic        ok_r;
  logic [15:0] days_r;
  logic [16:0] tod_r;
  logic [31:0] prod_r;
  logic        out_valid_r;
  out_data_t   out_data_r;

  // character intake
  logic [7:0] want;
  logic       is_digit, digit_ok, past_end;
  logic [3:0] dg;
  logic [13:0] year_fold;
  logic [6:0]  small_acc, small_fold;

  always_comb begin
    want     = expected_char(pos_r);
    past_end = (pos_r >= POS_LAST);
    is_digit = (want == DIGIT_SLOT);
    digit_ok = (in_data.char_code >= 8'h30) && (in_data.char_code <= 8'h39);
    dg       = in_data.char_code[3:0];
    year_fold = {year_r[10:0], 3'b000} + {year_r[12:0], 1'b0} + {10'd0, dg};
    if (pos_r < 5'd7)       small_acc = month_r;
    else if (pos_r < 5'd10) small_acc = day_r;
    else if (pos_r < 5'd13) small_acc = hour_r;
    else if (pos_r < 5'd16) small_acc = min_r;
    else                    small_acc = sec_r;
    small_fold = {small_acc[3:0], 3'b000} + {small_acc[5:0], 1'b0} + {3'd0, dg};
  end

  // conversion step one
  logic        leap, range_ok;
  logic [7:0]  yoff;
  logic [5:0]  leaps;
  logic [15:0] days_nxt;
  logic [16:0] tod_nxt;

  always_comb begin
    leap     = (year_r[1:0] == 2'b00);  // exact for 1970..2099
    range_ok = !failed_r && (pos_r == POS_LAST) &&
               (year_r >= YEAR_MIN) && (year_r <= YEAR_MAX) &&
               (month_r >= 7'd1) && (month_r <= 7'd12) && (day_r >= 7'd1) &&
               (day_r <= {2'b00, month_length(month_r[3:0], leap)}) &&
               (hour_r <= 7'd23) && (min_r <= 7'd59) && (sec_r <= 7'd59);
    yoff  = 8'(year_r - YEAR_MIN);
    leaps = 6'((yoff + 8'd1) >> 2);
    days_nxt = 16'(16'(yoff) * 16'd365) + 16'(leaps) +
               16'(days_before_month(month_r[3:0])) +
               16'(leap && (month_r > 7'd2)) + 16'(day_r) - 16'd1;
    tod_nxt = 17'(17'(hour_r[4:0]) * 17'd3600) + 17'(17'(min_r[5:0]) * 17'd60) +
              17'(sec_r[5:0]);
  end

  // conversion step three
  logic [31:0] local_sec;
  logic        res_ok;

  always_comb begin
    local_sec = prod_r + 32'(tod_r);
    res_ok    = ok_r && (local_sec >= OFFSET_SECONDS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.fin_load) begin
      pos_r    <= '0;
      failed_r <= 1'b0;
      year_r   <= '0;
      month_r  <= '0;
      day_r    <= '0;
      hour_r   <= '0;
      min_r    <= '0;
      sec_r    <= '0;
    end else if (cmd.take) begin
      if (past_end) begin
        failed_r <= 1'b1;
      end else begin
        pos_r <= pos_r + 5'd1;
        if (is_digit) begin
          if (!digit_ok) begin
            failed_r <= 1'b1;
          end else if (pos_r < 5'd4) begin
            year_r <= year_fold;
          end else if (pos_r < 5'd7) begin
            month_r <= small_fold;
          end else if (pos_r < 5'd10) begin
            day_r <= small_fold;
          end else if (pos_r < 5'd13) begin
            hour_r <= small_fold;
          end else if (pos_r < 5'd16) begin
            min_r <= small_fold;
          end else begin
            sec_r <= small_fold;
          end
        end else if (in_data.char_code != want) begin
          failed_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      ok_r   <= range_ok;
      days_r <= days_nxt;
      tod_r  <= tod_nxt;
    end
    if (cmd.mul) begin
      prod_r <= 32'(days_r) * SEC_PER_DAY;
    end
    if (cmd.fin_load) begin
      out_data_r.epoch_seconds <= res_ok ? (local_sec - OFFSET_SECONDS) : 32'd0;
      out_data_r.valid_res     <= res_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.out_full = out_valid_r && !out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

// ===== rtl/core/iso8601_fixed_offset_to_epoch.sv =====
// Top level: YYYY-MM-DDThh:mm:ss+07:00 character stream to UTC epoch seconds.
// Characters are taken while the sequencer is idle; the last one starts the range
// check and day count, the days-to-seconds multiply and the offset and result
// load, which waits while out_full is set. The result register lets the next
// text's characters flow while a result waits. Synchronous active-low reset
// returns the sequencer to intake, clears all text state and drops out_valid.
module iso8601_fixed_offset_to_epoch
  import iso_epoch_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_data_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_data_t out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  iso_epoch_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_is_last (in_data.is_last),
    .in_ready   (in_ready),
    .status     (status),
    .cmd        (cmd)
  );

  iso_epoch_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/iso8601_fixed_offset_to_epoch_tb.sv =====
// Testbench for the ISO 8601 (+07:00) character stream to UTC epoch converter.
module iso8601_fixed_offset_to_epoch_tb
  import iso_epoch_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef byte unsigned text_t[$];

  // 'd' marks a digit slot, anything else is the literal character required
  localparam string SHAPE = "dddd-dd-ddTdd:dd:dd+07:00";
  localparam int RANDOM_CHARS = 1060;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_data_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_data_t out_data;

  iso8601_fixed_offset_to_epoch u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  in_data_t  char_q[$];
  out_data_t pending_epochs[$];

  // shadow of the converter's text state
  logic [4:0]  sh_pos = '0;
  bit          sh_failed = 1'b0;
  logic [13:0] sh_year = '0;
  logic [6:0]  sh_mon = '0, sh_day = '0, sh_hour = '0, sh_min = '0, sh_sec = '0;

  int  errors = 0;
  int  n_texts = 0, n_good = 0, n_bad = 0, n_chars = 0;
  bit  req_taken = 1'b0;
  int  gap_left = 0, stall_left = 0;
  bit  in_calm = 1'b0, out_calm = 1'b0;

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic bit leap_year(input int y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int month_len(input int y, input int m);
    case (m)
      2:             return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      1, 3, 5, 7, 8,
      10, 12:        return 31;
      default:       return 0;
    endcase
  endfunction

  // local seconds since 1970-01-01T00:00:00 for a range-checked date
  function automatic longint local_seconds(input int y, input int m, input int d,
                                           input int h, input int mi, input int s);
    int yy, era, yoe, doy, doe;
    longint days;
    yy   = y - ((m <= 2) ? 1 : 0);
    era  = yy / 400;
    yoe  = yy - era * 400;
    doy  = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = longint'(era) * 146097 + doe - 719468;
    return days * 86400 + h * 3600 + mi * 60 + s;
  endfunction

  task automatic track_char(input in_data_t req);
    byte unsigned want;
    int           dg;
    bit           ok;
    int           y, mo, d;
    longint       loc;
    out_data_t    res;
    n_chars++;
    if (sh_pos >= 5'(TEXT_LEN)) begin
      sh_failed = 1'b1;
    end else begin
      want = SHAPE[sh_pos];
      if (want == "d") begin
        if (req.char_code < 8'h30 || req.char_code > 8'h39) begin
          sh_failed = 1'b1;
        end else begin
          dg = req.char_code - 8'h30;
          if (sh_pos < 4)       sh_year = 14'(sh_year * 10 + dg);
          else if (sh_pos < 7)  sh_mon  = 7'(sh_mon * 10 + dg);
          else if (sh_pos < 10) sh_day  = 7'(sh_day * 10 + dg);
          else if (sh_pos < 13) sh_hour = 7'(sh_hour * 10 + dg);
          else if (sh_pos < 16) sh_min  = 7'(sh_min * 10 + dg);
          else                  sh_sec  = 7'(sh_sec * 10 + dg);
        end
      end else if (req.char_code != want) begin
        sh_failed = 1'b1;
      end
      sh_pos = sh_pos + 5'd1;
    end
    if (!req.is_last) return;

    y  = int'(sh_year);
    mo = int'(sh_mon);
    d  = int'(sh_day);
    loc = 0;
    ok = !sh_failed && sh_pos == 5'(TEXT_LEN);
    if (ok && (y < 1970 || y > 2099 || mo < 1 || mo > 12 || d < 1 ||
               d > month_len(y, mo) || sh_hour > 23 || sh_min > 59 || sh_sec > 59))
      ok = 1'b0;
    if (ok) begin
      loc = local_seconds(y, mo, d, int'(sh_hour), int'(sh_min), int'(sh_sec));
      if (loc < longint'(OFFSET_SECONDS)) ok = 1'b0;
    end
    res.valid_res     = ok;
    res.epoch_seconds = ok ? 32'(loc - longint'(OFFSET_SECONDS)) : 32'd0;
    pending_epochs.push_back(res);
    n_texts++;
    if (ok) n_good++; else n_bad++;

    sh_pos = '0; sh_failed = 1'b0; sh_year = '0;
    sh_mon = '0; sh_day = '0; sh_hour = '0; sh_min = '0; sh_sec = '0;
  endtask

  function automatic text_t to_bytes(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  task automatic push_bytes(input text_t t);
    in_data_t r;
    foreach (t[i]) begin
      r.char_code = t[i];
      r.is_last   = (i == t.size() - 1);
      char_q.push_back(r);
    end
  endtask

  function automatic string stamp(input int y, input int mo, input int d,
                                  input int h, input int mi, input int s);
    return $sformatf("%04d-%02d-%02dT%02d:%02d:%02d+07:00", y, mo, d, h, mi, s);
  endfunction

  // mostly well-formed timestamps near the edges, some broken or noise
  function automatic text_t random_text();
    int    kind, r, y, mo, d, h, mi, s, n, lim;
    text_t t;
    kind = $urandom_range(0, 99);
    r = $urandom_range(0, 9);
    case (r)
      0:       y = 1970;
      1:       y = 2099;
      2:       y = $urandom_range(0, 1) ? $urandom_range(1960, 1969) : $urandom_range(2100, 2110);
      3:       y = $urandom_range(0, 9999);
      default: y = $urandom_range(1970, 2099);
    endcase
    mo = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 12) : $urandom_range(0, 99);
    lim = month_len(y, mo);
    if (lim == 0) lim = 28;
    r = $urandom_range(0, 19);
    if (r < 15)      d = $urandom_range(1, lim);
    else if (r < 17) d = lim;
    else if (r < 18) d = lim + 1;
    else             d = $urandom_range(0, 99);
    h  = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 23) : $urandom_range(24, 99);
    mi = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 59) : $urandom_range(60, 99);
    s  = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 59) : $urandom_range(60, 99);
    if ($urandom_range(0, 19) == 0) begin
      // straddle the epoch in local time
      y = 1970; mo = 1; d = 1; h = $urandom_range(5, 8);
    end
    t = to_bytes(stamp(y, mo, d, h, mi, s));
    if (kind < 70) begin
    end else if (kind < 80) begin
      t[$urandom_range(0, 24)] = 8'($urandom_range(0, 255));
    end else if (kind < 87) begin
      n = $urandom_range(1, 24);
      while (t.size() > n) void'(t.pop_back());
    end else if (kind < 94) begin
      n = $urandom_range(1, 8);
      repeat (n) t.push_back(8'($urandom_range(0, 255)));
    end else begin
      t.delete();
      n = $urandom_range(1, 30);
      repeat (n) t.push_back(8'($urandom_range(0, 255)));
    end
    return t;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk) begin
    out_data_t want_res;
    req_taken = rst_n && in_valid && in_ready;
    if (req_taken) track_char(in_data);
    if (rst_n && out_valid && out_ready) begin
      if (pending_epochs.size() == 0) begin
        report($sformatf("result %0d/%0d with no text pending",
                         out_data.epoch_seconds, out_data.valid_res));
      end else begin
        want_res = pending_epochs.pop_front();
        if (out_data.valid_res !== want_res.valid_res)
          report($sformatf("valid_res got %b want %b (epoch want %0d)",
                           out_data.valid_res, want_res.valid_res,
                           want_res.epoch_seconds));
        if (out_data.epoch_seconds !== want_res.epoch_seconds)
          report($sformatf("epoch_seconds got %0d want %0d",
                           out_data.epoch_seconds, want_res.epoch_seconds));
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (char_q.size() > 0) begin
        in_data  <= char_q.pop_front();
        in_valid <= 1'b1;
        gap_left = in_calm ? 0 : pick_gap();
        if ($urandom_range(0, 199) == 0) in_calm = !in_calm;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result-side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!out_calm && $urandom_range(0, 99) < 30) stall_left = pick_gap();
      if ($urandom_range(0, 299) == 0) out_calm = !out_calm;
    end
  end

  initial begin
    string directed[$];
    text_t t;
    int    random_chars;
    directed = '{
      "2024-02-29T12:34:56+07:00",   // leap day
      "1970-01-01T07:00:00+07:00",   // epoch zero
      "1970-01-01T06:59:59+07:00",   // one second before the epoch
      "2099-12-31T23:59:59+07:00",   // latest accepted
      "1969-12-31T23:59:59+07:00",
      "2100-01-01T00:00:00+07:00",
      "2023-02-29T00:00:00+07:00",   // not a leap year
      "2000-02-29T23:00:00+07:00",   // century leap year
      "2021-00-10T10:10:10+07:00",
      "2021-13-10T10:10:10+07:00",
      "2021-06-00T10:10:10+07:00",
      "2021-04-31T10:10:10+07:00",
      "2021-01-32T10:10:10+07:00",
      "2021-06-15T24:00:00+07:00",
      "2021-06-15T12:60:00+07:00",
      "2021-06-15T12:00:60+07:00",
      "2021-06-15 12:00:00+07:00",
      "2021-06-15T12:00:00+08:00",
      "2021/06/15T12:00:00+07:00",
      "2O21-06-15T12:00:00+07:00",
      "2021-06-15",                  // too short
      "2021-06-15T12:00:00+07:00ZZZ" // too long
    };
    foreach (directed[i]) push_bytes(to_bytes(directed[i]));
    t = to_bytes("2021-06-15T12:00:00+07:00");
    t[0] = 8'h00;
    push_bytes(t);
    t = to_bytes("2021-06-15T12:00:00+07:00");
    t[12] = 8'hFF;
    push_bytes(t);
    t = '{8'h37};
    push_bytes(t);

    random_chars = 0;
    while (random_chars < RANDOM_CHARS) begin
      t = random_text();
      random_chars += t.size();
      push_bytes(t);
    end

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (char_q.size() != 0 || in_valid || pending_epochs.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("streamed %0d characters in %0d texts: %0d converted, %0d rejected",
             n_chars, n_texts, n_good, n_bad);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", pending_epochs.size());
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/iso_epoch_pkg.sv
rtl/core/iso_epoch_ctrl.sv
rtl/core/iso_epoch_dp.sv
rtl/core/iso8601_fixed_offset_to_epoch.sv
tb/sv/iso8601_fixed_offset_to_epoch_tb.sv
